>>> hw/rtl/tppc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package tppc_pkg;
  localparam int COUNTER_BITS_DEF = 16;
  localparam int FREQ_W = 27;
  localparam int CLK_W = 27;
  localparam int VAL_W = 16;
  localparam logic [CLK_W-1:0] CLK_RESET = 27'd72000000;
endpackage
`default_nettype wire

>>> hw/rtl/tppc_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface tppc_in_if;
  import tppc_pkg::*;
  logic valid;
  logic ready;
  logic [FREQ_W-1:0] wanted_freq_hz;
  modport source (output valid, output wanted_freq_hz, input ready);
  modport sink (input valid, input wanted_freq_hz, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/tppc_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface tppc_out_if;
  import tppc_pkg::*;
  logic valid;
  logic ready;
  logic [VAL_W-1:0] prescale_value;
  logic [VAL_W-1:0] period_value;
  logic [VAL_W-1:0] spare_ticks;
  logic saturated;
  modport source (output valid, output prescale_value, output period_value,
                  output spare_ticks, output saturated, input ready);
  modport sink (input valid, input prescale_value, input period_value,
                input spare_ticks, input saturated, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/tppc_div_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module tppc_div_cell #(
  parameter int VW = 27,
  parameter int DW = 32,
  parameter int SW = 8
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          ce,
  input  wire logic          valid_i,
  input  wire logic [VW-1:0] rem_i,
  input  wire logic [DW-1:0] dq_i,
  input  wire logic [VW-1:0] div_i,
  input  wire logic [SW-1:0] side_i,
  output logic               valid_o,
  output logic [VW-1:0]      rem_o,
  output logic [DW-1:0]      dq_o,
  output logic [VW-1:0]      div_o,
  output logic [SW-1:0]      side_o
);
  logic [VW:0] t;
  logic [VW:0] diff;
  logic        ge;
  logic [VW-1:0] rem_nxt;

  // one restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    t = {rem_i, dq_i[DW-1]};
    ge = t >= {1'b0, div_i};
    diff = t - {1'b0, div_i};
    rem_nxt = ge ? diff[VW-1:0] : t[VW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_o <= 1'b0;
    end else if (ce) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      rem_o <= rem_nxt;
      dq_o <= {dq_i[DW-2:0], ge};
      div_o <= div_i;
      side_o <= side_i;
    end
  end
endmodule
`default_nettype wire

>>> hw/rtl/tppc_div_chain.sv
`timescale 1ns / 1ps
`default_nettype none
module tppc_div_chain #(
  parameter int VW = 27,
  parameter int DW = 32,
  parameter int SW = 8
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          ce,
  input  wire logic          valid_i,
  input  wire logic [DW-1:0] dividend_i,
  input  wire logic [VW-1:0] divisor_i,
  input  wire logic [SW-1:0] side_i,
  output logic               valid_o,
  output logic [DW-1:0]      quot_o,
  output logic [SW-1:0]      side_o
);
  logic          v [DW+1];
  logic [VW-1:0] rem [DW+1];
  logic [DW-1:0] dq [DW+1];
  logic [VW-1:0] dv [DW+1];
  logic [SW-1:0] sd [DW+1];

  assign v[0] = valid_i;
  assign rem[0] = '0;
  assign dq[0] = dividend_i;
  assign dv[0] = divisor_i;
  assign sd[0] = side_i;

  for (genvar i = 0; i < DW; i++) begin : g_cell
    tppc_div_cell #(.VW(VW), .DW(DW), .SW(SW)) u_cell (
      .clk(clk), .rst_n(rst_n), .ce(ce),
      .valid_i(v[i]), .rem_i(rem[i]), .dq_i(dq[i]), .div_i(dv[i]), .side_i(sd[i]),
      .valid_o(v[i+1]), .rem_o(rem[i+1]), .dq_o(dq[i+1]), .div_o(dv[i+1]),
      .side_o(sd[i+1])
    );
  end

  // final remainder and divisor are not needed downstream
  logic unused_tail;
  assign unused_tail = ^{rem[DW], dv[DW]};

  assign valid_o = v[DW];
  assign quot_o = dq[DW];
  assign side_o = sd[DW];
endmodule
`default_nettype wire

>>> hw/rtl/timer_prescale_period_calc_top.sv
`timescale 1ns / 1ps
`default_nettype none
// timer prescale / reload calculator
// in_ch carries a wanted overflow frequency; out_ch returns the prescaler
// register value, the reload value, the spare ticks and a saturation flag.
// cfg_we/cfg_wdata write the timer input clock in hertz (reset 72 MHz);
// write it only while no transaction is in flight.
// the work is a row of one-bit restoring divider cells in three chains:
// prescale quotient (37-COUNTER_BITS cells), clock over ratio (32 cells)
// and period over frequency (33 cells), then one output register.
// a new transaction is taken every cycle while in_ch.ready is high.
// reset empties the chains and restores the clock register.
// when the receiver stalls with a result held, the chains freeze and
// in_ch.ready drops, unless the last cell is empty, so no result is lost.
module timer_prescale_period_calc_top #(
  parameter int COUNTER_BITS = tppc_pkg::COUNTER_BITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  tppc_in_if.sink               in_ch,
  tppc_out_if.source            out_ch,
  input  wire logic             cfg_we,
  input  wire logic [tppc_pkg::CLK_W-1:0] cfg_wdata
);
  import tppc_pkg::*;

  localparam int N = COUNTER_BITS;
  localparam int FXW = CLK_W + 5;        // clock in 27.5 fixed point
  localparam int PW = FXW + 5 - N;       // prescale dividend width
  localparam int RW = PW - 8;            // divide ratio width
  localparam int D3W = FXW + 1;          // period dividend width
  localparam int PERW = D3W + 1 - 5;     // rounded period width
  localparam logic [31:0] CNT_MAX = (32'd1 << N) - 32'd1;

  // clock register
  logic [CLK_W-1:0] clk_hz_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clk_hz_r <= CLK_RESET;
    end else if (cfg_we) begin
      clk_hz_r <= cfg_wdata;
    end
  end

  // global advance: stall only when a held result would be overwritten
  logic ce;
  logic v3;
  logic out_valid_r;
  assign ce = out_ch.ready || !out_valid_r || !v3;
  assign in_ch.ready = ce;

  // front end: branch test and prescale dividend
  logic [FXW-1:0]   fxp_in;
  logic             big_ratio;
  logic [PW-5:0]    p_hi;
  logic [PW-1:0]    p_div;
  always_comb begin
    fxp_in = {clk_hz_r, 5'b0};
    // clk/freq > max  <=>  (clk >> N) >= freq
    big_ratio = (clk_hz_r >> N) >= in_ch.wanted_freq_hz;
    p_hi = (PW-4)'(fxp_in >> N) + (PW-4)'(16);
    p_div = {p_hi, 4'b0};
  end

  localparam int S1W = 1 + FREQ_W + CLK_W;
  logic           v1;
  logic [PW-1:0]  q1;
  logic [S1W-1:0] s1;
  tppc_div_chain #(.VW(FREQ_W), .DW(PW), .SW(S1W)) u_div_pre (
    .clk(clk), .rst_n(rst_n), .ce(ce),
    .valid_i(in_ch.valid && ce), .dividend_i(p_div),
    .divisor_i(in_ch.wanted_freq_hz),
    .side_i({big_ratio, in_ch.wanted_freq_hz, clk_hz_r}),
    .valid_o(v1), .quot_o(q1), .side_o(s1)
  );

  // ratio: round with +256, then ceiling of /512
  logic             c1;
  logic [FREQ_W-1:0] f1;
  logic [CLK_W-1:0] k1;
  logic [PW:0]      q1s;
  logic [RW-1:0]    ratio_c;
  logic [RW-1:0]    ratio;
  always_comb begin
    {c1, f1, k1} = s1;
    q1s = {1'b0, q1} + (PW+1)'(256);
    ratio_c = q1s[PW:9] + RW'(|q1s[8:0]);
    ratio = c1 ? ratio_c : RW'(1);
    if (ratio == '0) begin
      ratio = RW'(1);
    end
  end

  localparam int S2W = FREQ_W + RW;
  logic           v2;
  logic [FXW-1:0] q2;
  logic [S2W-1:0] s2;
  tppc_div_chain #(.VW(RW), .DW(FXW), .SW(S2W)) u_div_clk (
    .clk(clk), .rst_n(rst_n), .ce(ce),
    .valid_i(v1), .dividend_i({k1, 5'b0}), .divisor_i(ratio),
    .side_i({f1, ratio}),
    .valid_o(v2), .quot_o(q2), .side_o(s2)
  );

  logic [FREQ_W-1:0] f2;
  logic [RW-1:0]     r2;
  logic [D3W-1:0]    d3;
  always_comb begin
    {f2, r2} = s2;
    d3 = {1'b0, q2} + D3W'(16);
  end

  localparam int S3W = RW + 1;
  logic [D3W-1:0] q3;
  logic [S3W-1:0] s3;
  tppc_div_chain #(.VW(FREQ_W), .DW(D3W), .SW(S3W)) u_div_per (
    .clk(clk), .rst_n(rst_n), .ce(ce),
    .valid_i(v2), .dividend_i(d3), .divisor_i(f2),
    .side_i({f2 == '0, r2}),
    .valid_o(v3), .quot_o(q3), .side_o(s3)
  );

  // back end: half-step rounding, register form, clamp
  logic             fz;
  logic [RW-1:0]    r3;
  logic [D3W:0]     q3s;
  logic [PERW-1:0]  per;
  logic [RW-1:0]    ratio_m1;
  logic [PERW-1:0]  per_m1;
  logic             sat_p;
  logic             sat_q;
  logic [VAL_W-1:0] pre_v;
  logic [VAL_W-1:0] per_v;
  logic [VAL_W-1:0] spare_v;
  logic             sat_v;
  always_comb begin
    {fz, r3} = s3;
    q3s = {1'b0, q3} + (D3W+1)'(16);
    per = q3s[D3W:5];
    ratio_m1 = r3 - RW'(1);
    per_m1 = (per != '0) ? per - PERW'(1) : '0;
    sat_p = 32'(ratio_m1) > CNT_MAX;
    sat_q = 32'(per_m1) > CNT_MAX;
    pre_v = sat_p ? VAL_W'(CNT_MAX) : VAL_W'(ratio_m1);
    per_v = sat_q ? VAL_W'(CNT_MAX) : VAL_W'(per_m1);
    sat_v = sat_p || sat_q;
    // zero frequency: nothing to divide by, report full scale
    if (fz) begin
      pre_v = VAL_W'(CNT_MAX);
      per_v = VAL_W'(CNT_MAX);
      sat_v = 1'b1;
    end
    spare_v = VAL_W'(CNT_MAX) - per_v;
  end

  // output register; holds while the receiver stalls
  logic [VAL_W-1:0] pre_r, per_r, spare_r;
  logic             sat_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ch.ready || !out_valid_r) begin
      out_valid_r <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ch.ready || !out_valid_r) begin
      pre_r <= pre_v;
      per_r <= per_v;
      spare_r <= spare_v;
      sat_r <= sat_v;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.prescale_value = pre_r;
  assign out_ch.period_value = per_r;
  assign out_ch.spare_ticks = spare_r;
  assign out_ch.saturated = sat_r;
endmodule
`default_nettype wire

>>> tb/sv/timer_prescale_period_calc_top_tb.sv
`timescale 1ns / 1ps
module timer_prescale_period_calc_top_tb;
  import tppc_pkg::*;

  localparam int CNT_BITS = COUNTER_BITS_DEF;
  localparam longint unsigned CNT_MAX = (64'd1 << CNT_BITS) - 1;
  // pipeline is 103-COUNTER_BITS deep; settle pause after drain covers it
  localparam int SETTLE_CYCLES = 120;
  // quiet cycles tolerated; longest hold-off plus settle pause, several times over
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int LONG_HOLD = 300;

  typedef struct packed {
    logic [VAL_W-1:0] prescale_value;
    logic [VAL_W-1:0] period_value;
    logic [VAL_W-1:0] spare_ticks;
    logic             saturated;
  } timer_setting_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CLK_W-1:0] cfg_wdata;

  tppc_in_if  in_if ();
  tppc_out_if out_if ();

  timer_prescale_period_calc_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_if),
    .out_ch   (out_if),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // predictor copy of the clock register
  logic [CLK_W-1:0] clock_hz;
  timer_setting_t   setting_q[$];

  int  err_count;
  int  freqs_sent;
  int  settings_checked;
  int  clocks_written;
  bit  tx_fast;
  bit  rx_fast;
  int  rx_stall_left;
  int  rx_hold_req;
  int  quiet_cycles;

  // 125 MHz tb clock, 8 ns period
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // work out prescale and reload for one wanted frequency
  function automatic timer_setting_t calc_timer_setting(logic [FREQ_W-1:0] freq_hz,
                                                        logic [CLK_W-1:0] clk_hz);
    longint unsigned freq;
    longint unsigned fxp;
    longint unsigned ratio;
    longint unsigned period;
    longint unsigned acc;
    longint unsigned whole;
    timer_setting_t  res;
    freq  = freq_hz;
    fxp   = longint'(clk_hz) << 5;
    ratio = 1;
    res.saturated = 1'b0;
    // nothing to divide by: prescale and period pinned at the counter max, no spare ticks
    if (freq == 0) begin
      res.prescale_value = CNT_MAX[VAL_W-1:0];
      res.period_value   = CNT_MAX[VAL_W-1:0];
      res.spare_ticks    = '0;
      res.saturated      = 1'b1;
      return res;
    end
    // clock too fast for a bare counter: ceiling of the rounded prescale ratio
    if (longint'(clk_hz) / freq > CNT_MAX) begin
      acc   = ((fxp >> CNT_BITS) + 16) << 4;
      acc   = acc / freq + 256;
      whole = acc >> 9;
      if (acc > (whole << 9)) whole++;
      ratio = whole;
    end
    if (ratio == 0) ratio = 1;
    period = ((fxp / ratio + 16) / freq + 16) >> 5;
    ratio  = ratio - 1;
    if (period > 0) period--;
    if (ratio > CNT_MAX) begin
      ratio = CNT_MAX;
      res.saturated = 1'b1;
    end
    if (period > CNT_MAX) begin
      period = CNT_MAX;
      res.saturated = 1'b1;
    end
    res.prescale_value = ratio[VAL_W-1:0];
    res.period_value   = period[VAL_W-1:0];
    res.spare_ticks    = CNT_MAX[VAL_W-1:0] - period[VAL_W-1:0];
    return res;
  endfunction

  // result side: compare every accepted transaction against the oldest expectation
  always @(posedge clk) begin
    timer_setting_t got;
    timer_setting_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      got.prescale_value = out_if.prescale_value;
      got.period_value   = out_if.period_value;
      got.spare_ticks    = out_if.spare_ticks;
      got.saturated      = out_if.saturated;
      if (setting_q.size() == 0) begin
        err_count++;
        $display("%0t: unexpected result %h", $time, got);
      end else begin
        want = setting_q.pop_front();
        settings_checked++;
        if (got.prescale_value !== want.prescale_value) begin
          err_count++;
          $display("%0t: prescale_value expected %0d got %0d", $time,
                   want.prescale_value, got.prescale_value);
        end
        if (got.period_value !== want.period_value) begin
          err_count++;
          $display("%0t: period_value expected %0d got %0d", $time,
                   want.period_value, got.period_value);
        end
        if (got.spare_ticks !== want.spare_ticks) begin
          err_count++;
          $display("%0t: spare_ticks expected %0d got %0d", $time,
                   want.spare_ticks, got.spare_ticks);
        end
        if (got.saturated !== want.saturated) begin
          err_count++;
          $display("%0t: saturated expected %0b got %0b", $time,
                   want.saturated, got.saturated);
        end
      end
      // fresh stall draw for the next result
      rx_stall_left = rx_fast ? 0 : $urandom_range(0, 16);
    end
  end

  // result-side ready: one assignment per falling edge; long hold-offs counted here
  initial begin
    rx_stall_left = 0;
    rx_hold_req   = 0;
    forever begin
      @(negedge clk);
      if (rx_hold_req > 0) begin
        rx_stall_left = rx_hold_req;
        rx_hold_req   = 0;
      end
      out_if.ready <= (rx_stall_left == 0) && rst_n;
      if (rx_stall_left > 0) rx_stall_left--;
    end
  end

  // watchdog: cycles with no transaction on either side
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
      quiet_cycles <= 0;
    else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired, %0d results outstanding", $time,
                 setting_q.size());
        $display("timer_prescale_period_calc_top_tb: done, errors");
        $finish;
      end
    end
  end

  // offer one wanted frequency, wait for the handshake, log the expectation
  task automatic send_freq(logic [FREQ_W-1:0] freq_hz);
    int gap;
    gap = tx_fast ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      @(negedge clk);
      in_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_if.valid          <= 1'b1;
    in_if.wanted_freq_hz <= freq_hz;
    do @(posedge clk); while (!in_if.ready);
    setting_q.push_back(calc_timer_setting(freq_hz, clock_hz));
    freqs_sent++;
  endtask

  // stop offering, wait for every result, then let the chains settle
  task automatic drain();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (setting_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // clock register write, only with the block idle
  task automatic write_clock(logic [CLK_W-1:0] hz);
    drain();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= hz;
    @(negedge clk);
    cfg_we    <= 1'b0;
    clock_hz = hz;
    clocks_written++;
  endtask

  // mixed frequency draw: full range, prescale path, near the boundary, log spread
  function automatic logic [FREQ_W-1:0] rand_freq();
    logic [FREQ_W-1:0] f;
    case ($urandom_range(0, 3))
      0: f = FREQ_W'($urandom_range(1, (1 << FREQ_W) - 1));
      1: f = FREQ_W'($urandom_range(1, 1100));
      2: f = FREQ_W'($urandom_range(1, 4000));
      default: f = FREQ_W'($urandom() >> $urandom_range(5, 31));
    endcase
    if (f == 0) f = 1;
    return f;
  endfunction

  // extremes of the frequency field plus the zero-frequency corner, at extreme clock settings
  task automatic test_directed();
    send_freq(27'd1);
    send_freq(27'h7FFFFFF);
    send_freq(27'd0);
    send_freq(27'd1000);
    send_freq(27'd1098);
    send_freq(27'd1099);
    send_freq(27'd1100);
    send_freq(27'd72000000);
    send_freq(27'd72000001);
    send_freq(27'd36000000);
    // clock below frequency, period rounds up to one count, register value zero
    send_freq(27'd100000000);
    write_clock(27'd1);
    send_freq(27'd1);
    send_freq(27'd2);
    send_freq(27'h7FFFFFF);
    write_clock(27'h7FFFFFF);
    send_freq(27'd1);
    send_freq(27'd2048);
    send_freq(27'h7FFFFFF);
    // zero clock: ratio 1, period 0
    write_clock(27'd0);
    send_freq(27'd1);
    send_freq(27'd5);
    send_freq(27'd0);
    write_clock(CLK_RESET);
  endtask

  // receiver holds off long while the sender keeps pushing
  task automatic test_backpressure();
    tx_fast = 1'b1;
    @(negedge clk);
    rx_hold_req = LONG_HOLD;
    repeat (200) send_freq(rand_freq());
    tx_fast = 1'b0;
    drain();
  endtask

  // sender pauses until the pipe has fully emptied between bursts
  task automatic test_drain_pause();
    repeat (3) begin
      repeat ($urandom_range(5, 30)) send_freq(rand_freq());
      drain();
    end
  endtask

  // random frequencies across several clock settings, fast and slow stretches
  task automatic test_random_clocks();
    logic [CLK_W-1:0] clk_list[6];
    clk_list = '{27'd72000000, 27'd8000000, 27'h7FFFFFF, 27'd1, 27'd16000000, 27'd0};
    for (int i = 0; i < 6; i++) begin
      write_clock(i == 5 ? CLK_W'($urandom_range(1, (1 << CLK_W) - 1)) : clk_list[i]);
      tx_fast = (i % 2) == 1;
      rx_fast = (i % 3) == 2;
      repeat (130) send_freq(rand_freq());
      tx_fast = 1'b0;
      rx_fast = 1'b0;
    end
    for (int i = 0; i < 3; i++) begin
      write_clock(CLK_W'($urandom_range(1, (1 << CLK_W) - 1)));
      repeat (30) send_freq(rand_freq());
    end
    drain();
  endtask

  initial begin
    err_count        = 0;
    freqs_sent       = 0;
    settings_checked = 0;
    clocks_written   = 0;
    tx_fast          = 1'b0;
    rx_fast          = 1'b0;
    quiet_cycles     = 0;
    clock_hz         = CLK_RESET;
    in_if.valid          = 1'b0;
    in_if.wanted_freq_hz = '0;
    out_if.ready         = 1'b0;
    cfg_we               = 1'b0;
    cfg_wdata            = '0;
    rst_n                = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_backpressure();
    test_drain_pause();
    test_random_clocks();

    $display("covered %0d frequency requests, %0d results checked, %0d clock writes",
             freqs_sent, settings_checked, clocks_written);
    $display("clock settings spanned zero, one, full scale and random values");
    if (err_count == 0) begin
      $display("timer_prescale_period_calc_top_tb: done, clean");
    end else begin
      $display("timer_prescale_period_calc_top_tb: done, errors");
    end
    $finish;
  end
endmodule

>>> timer_prescale_period_calc_top.f
hw/rtl/tppc_pkg.sv
hw/rtl/tppc_in_if.sv
hw/rtl/tppc_out_if.sv
hw/rtl/tppc_div_cell.sv
hw/rtl/tppc_div_chain.sv
hw/rtl/timer_prescale_period_calc_top.sv
tb/sv/timer_prescale_period_calc_top_tb.sv
